// ----- hdl/iem_pkg.sv -----
`timescale 1ns / 1ps
// Package for the I2C EEPROM master: item kinds, queue entry type,
// line-sequencer phase codes, hold constants and register indexes. No dependencies.
package iem_pkg;

    // Opcode values of an incoming transaction
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_WRITE_WAIT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [6:0]  SLAVE_ADDR_RST = 7'h50;
    localparam logic [15:0] WRITE_WAIT_RST = 16'd10000;

    // Hold counts are loaded as (ticks - 1)
    localparam logic [15:0] HOLD_1 = 16'd0;
    localparam logic [15:0] HOLD_2 = 16'd1;
    localparam logic [15:0] HOLD_3 = 16'd2;
    localparam logic [15:0] HOLD_5 = 16'd4;

    // Bits in a byte, as a bit counter value
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Byte selector codes
    localparam logic [2:0] SEL_DEV    = 3'd0;
    localparam logic [2:0] SEL_ADDR_H = 3'd1;
    localparam logic [2:0] SEL_ADDR_L = 3'd2;
    localparam logic [2:0] SEL_LAST   = 3'd3;

    // Classified transaction kind
    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_WRITE = 2'd1,
        K_READ  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    // Entry of the queue between front and engine
    typedef struct packed {
        t_kind       kind;
        logic [15:0] mem_addr;
        logic [7:0]  byte_count;
        logic [7:0]  write_byte;
        logic        sda_in;
    } t_item;

    // Queue to engine handshake
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_out;

    // Line sequencer phases, one-hot
    typedef enum logic [23:0] {
        PH_IDLE   = 24'h000001,
        PH_S0     = 24'h000002,
        PH_S1     = 24'h000004,
        PH_S2     = 24'h000008,
        PH_S3     = 24'h000010,
        PH_WBIT   = 24'h000020,
        PH_WHI    = 24'h000040,
        PH_WLO    = 24'h000080,
        PH_AREL   = 24'h000100,
        PH_AHI    = 24'h000200,
        PH_ASMP   = 24'h000400,
        PH_ALO    = 24'h000800,
        PH_RREL   = 24'h001000,
        PH_RHI    = 24'h002000,
        PH_RSMP   = 24'h004000,
        PH_RLO    = 24'h008000,
        PH_KDRV   = 24'h010000,
        PH_KHI    = 24'h020000,
        PH_KLO    = 24'h040000,
        PH_T0     = 24'h080000,
        PH_T1     = 24'h100000,
        PH_T2     = 24'h200000,
        PH_TAFTER = 24'h400000,
        PH_FIN    = 24'h800000
    } t_phase;

endpackage

// ----- hdl/iem_in_if.sv -----
`timescale 1ns / 1ps
// Command/tick channel of the I2C EEPROM master.
// Stand-alone interface, no dependencies.
interface iem_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] mem_addr;
    logic [7:0]  byte_count;
    logic [7:0]  write_byte;
    logic        sda_in;

    modport source (output valid, opcode, mem_addr, byte_count, write_byte, sda_in,
                    input ready);
    modport sink (input valid, opcode, mem_addr, byte_count, write_byte, sda_in,
                  output ready);
endinterface

// ----- hdl/iem_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the I2C EEPROM master.
// Stand-alone interface, no dependencies.
interface iem_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_data;
    logic       last_byte;
    logic       done_res;
    logic       nack_error;

    modport source (output valid, scl_out, sda_out, busy_res, byte_valid, read_data,
                    last_byte, done_res, nack_error, input ready);
    modport sink (input valid, scl_out, sda_out, busy_res, byte_valid, read_data,
                  last_byte, done_res, nack_error, output ready);
endinterface

// ----- hdl/iem_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts transactions, classifies the opcode and queues them.
// Depends on iem_pkg and iem_in_if.
module iem_front #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    iem_in_if.sink          i_cmd,
    output iem_pkg::t_q_out o_q,
    input  logic            i_pop
);
    import iem_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    t_item         w_item;
    logic          w_push, w_pop;

    // Opcode classification
    always_comb begin
        unique case (i_cmd.opcode)
            OP_TICK:  w_item.kind = K_TICK;
            OP_WRITE: w_item.kind = K_WRITE;
            OP_READ:  w_item.kind = K_READ;
            default:  w_item.kind = K_NONE;
        endcase
        w_item.mem_addr   = i_cmd.mem_addr;
        w_item.byte_count = i_cmd.byte_count;
        w_item.write_byte = i_cmd.write_byte;
        w_item.sda_in     = i_cmd.sda_in;
    end

    assign i_cmd.ready = (r_count != CNT_FULL);
    assign w_push      = i_cmd.valid && i_cmd.ready;
    assign w_pop       = i_pop && (r_count != '0);

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.item  = r_mem[r_rd_ptr];

endmodule

// ----- hdl/iem_engine.sv -----
`timescale 1ns / 1ps
// Back end: I2C line sequencer, one step per queued transaction, with a
// registered result stage. Depends on iem_pkg and iem_out_if.
module iem_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  iem_pkg::t_q_out i_q,
    output logic            o_pop,
    input  logic [6:0]      i_slave_addr,
    input  logic [15:0]     i_write_wait,
    iem_out_if.source       o_res
);
    import iem_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_wait, n_wait;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_left, n_left;
    logic        r_is_read, n_is_read;
    logic [7:0]  r_data, n_data;
    logic [2:0]  r_sel, n_sel;
    logic        r_err, n_err;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;

    logic        r_valid;
    logic        r_byte_valid, n_byte_valid;
    logic [7:0]  r_read_data, n_read_data;
    logic        r_last, n_last;
    logic        r_done, n_done;
    logic        r_nack, n_nack;
    logic        r_busy;
    logic        r_scl_o, r_sda_o;

    logic        w_take;
    logic [2:0]  w_sel_inc;
    logic [3:0]  w_bit_inc;
    t_item       w_it;

    // Byte to send for a selector value
    function automatic logic [7:0] load_byte(input logic [2:0] sel, input logic [6:0] sa,
                                             input logic [15:0] addr, input logic rd,
                                             input logic [7:0] data);
        logic [7:0] b;
        case (sel)
            SEL_DEV:    b = {sa, 1'b0};
            SEL_ADDR_H: b = addr[15:8];
            SEL_ADDR_L: b = addr[7:0];
            default:    b = rd ? {sa, 1'b1} : data;
        endcase
        return b;
    endfunction

    assign w_it      = i_q.item;
    assign w_take    = i_q.valid && (!r_valid || o_res.ready);
    assign o_pop     = w_take;
    assign w_sel_inc = r_sel + 3'd1;
    assign w_bit_inc = r_bit + 4'd1;

    // One sequencer step
    always_comb begin
        n_phase = r_phase;   n_wait = r_wait;       n_bit = r_bit;
        n_shift = r_shift;   n_addr = r_addr;       n_left = r_left;
        n_is_read = r_is_read; n_data = r_data;     n_sel = r_sel;
        n_err = r_err;       n_scl = r_scl;         n_sda = r_sda;
        n_byte_valid = 1'b0; n_read_data = '0;      n_last = 1'b0;
        n_done = 1'b0;       n_nack = 1'b0;
        case (w_it.kind)
            K_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (r_wait != '0) begin
                        n_wait = r_wait - 16'd1;
                    end else begin
                        unique case (r_phase)
                            PH_S0: begin n_sda = 1'b1; n_phase = PH_S1; n_wait = HOLD_3; end
                            PH_S1: begin n_scl = 1'b1; n_phase = PH_S2; n_wait = HOLD_3; end
                            PH_S2: begin n_sda = 1'b0; n_phase = PH_S3; n_wait = HOLD_3; end
                            PH_S3: begin
                                n_scl   = 1'b0;
                                n_shift = load_byte(r_sel, i_slave_addr, r_addr, r_is_read,
                                                    r_data);
                                n_bit   = '0;
                                n_phase = PH_WBIT;
                                n_wait  = HOLD_3;
                            end
                            PH_WBIT: begin
                                n_sda = r_shift[7]; n_phase = PH_WHI; n_wait = HOLD_3;
                            end
                            PH_WHI: begin n_scl = 1'b1; n_phase = PH_WLO; n_wait = HOLD_5; end
                            PH_WLO: begin
                                n_scl   = 1'b0;
                                n_shift = {r_shift[6:0], 1'b0};
                                n_bit   = w_bit_inc;
                                n_phase = (w_bit_inc >= BITS_PER_BYTE) ? PH_AREL : PH_WBIT;
                                n_wait  = HOLD_5;
                            end
                            PH_AREL: begin n_sda = 1'b1; n_phase = PH_AHI; n_wait = HOLD_3; end
                            PH_AHI:  begin n_scl = 1'b1; n_phase = PH_ASMP; n_wait = HOLD_3; end
                            PH_ASMP: begin
                                n_err = w_it.sda_in; n_phase = PH_ALO; n_wait = HOLD_2;
                            end
                            PH_ALO: begin
                                n_scl  = 1'b0;
                                n_wait = HOLD_5;
                                if (r_err) begin
                                    n_phase = PH_T0;
                                end else begin
                                    n_sel = w_sel_inc;
                                    if (!r_is_read && w_sel_inc > SEL_LAST) begin
                                        n_phase = PH_T0;
                                    end else if (r_is_read && w_sel_inc == SEL_LAST) begin
                                        n_phase = PH_S0;
                                    end else if (r_is_read && w_sel_inc > SEL_LAST) begin
                                        n_phase = PH_RREL;
                                    end else begin
                                        n_shift = load_byte(w_sel_inc, i_slave_addr, r_addr,
                                                            r_is_read, r_data);
                                        n_bit   = '0;
                                        n_phase = PH_WBIT;
                                    end
                                end
                            end
                            PH_RREL: begin
                                n_sda = 1'b1; n_shift = '0; n_bit = '0;
                                n_phase = PH_RHI; n_wait = HOLD_1;
                            end
                            PH_RHI: begin n_scl = 1'b1; n_phase = PH_RSMP; n_wait = HOLD_3; end
                            PH_RSMP: begin
                                n_shift = {r_shift[6:0], w_it.sda_in};
                                n_phase = PH_RLO;
                                n_wait  = HOLD_2;
                            end
                            PH_RLO: begin
                                n_scl   = 1'b0;
                                n_bit   = w_bit_inc;
                                n_phase = (w_bit_inc >= BITS_PER_BYTE) ? PH_KDRV : PH_RHI;
                                n_wait  = HOLD_5;
                            end
                            PH_KDRV: begin
                                n_sda        = (r_left > 8'd1) ? 1'b0 : 1'b1;
                                n_byte_valid = 1'b1;
                                n_read_data  = r_shift;
                                n_last       = (r_left <= 8'd1);
                                n_phase      = PH_KHI;
                                n_wait       = HOLD_1;
                            end
                            PH_KHI: begin n_scl = 1'b1; n_phase = PH_KLO; n_wait = HOLD_5; end
                            PH_KLO: begin
                                n_scl  = 1'b0;
                                n_wait = HOLD_5;
                                if (r_left > 8'd1) begin
                                    n_left  = r_left - 8'd1;
                                    n_phase = PH_RREL;
                                end else begin
                                    n_phase = PH_T0;
                                end
                            end
                            PH_T0: begin n_sda = 1'b0; n_phase = PH_T1; n_wait = HOLD_3; end
                            PH_T1: begin n_scl = 1'b1; n_phase = PH_T2; n_wait = HOLD_3; end
                            PH_T2: begin n_sda = 1'b1; n_phase = PH_TAFTER; n_wait = HOLD_3; end
                            // Stop finished: start the write wait or finish at once
                            PH_TAFTER: begin
                                if (!r_err && !r_is_read && i_write_wait != '0) begin
                                    n_phase = PH_FIN;
                                    n_wait  = i_write_wait - 16'd1;
                                end else begin
                                    n_done  = 1'b1;
                                    n_nack  = r_err;
                                    n_phase = PH_IDLE;
                                end
                            end
                            PH_FIN: begin
                                n_done = 1'b1; n_nack = r_err; n_phase = PH_IDLE;
                            end
                            default: n_phase = PH_IDLE;
                        endcase
                    end
                end
            end
            K_WRITE, K_READ: begin
                // Latch a command only while idle
                if (r_phase == PH_IDLE) begin
                    n_addr    = w_it.mem_addr;
                    n_left    = (w_it.byte_count == '0) ? 8'd1 : w_it.byte_count;
                    n_data    = w_it.write_byte;
                    n_is_read = (w_it.kind == K_READ);
                    n_sel     = SEL_DEV;
                    n_err     = 1'b0;
                    n_bit     = '0;
                    n_shift   = '0;
                    n_wait    = '0;
                    n_phase   = PH_S0;
                end
            end
            default: ;
        endcase
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_wait <= '0; r_bit <= '0; r_shift <= '0;
            r_addr <= '0; r_left <= '0; r_is_read <= 1'b0; r_data <= '0;
            r_sel <= SEL_DEV; r_err <= 1'b0; r_scl <= 1'b1; r_sda <= 1'b1;
        end else if (w_take) begin
            r_phase <= n_phase; r_wait <= n_wait; r_bit <= n_bit; r_shift <= n_shift;
            r_addr <= n_addr; r_left <= n_left; r_is_read <= n_is_read; r_data <= n_data;
            r_sel <= n_sel; r_err <= n_err; r_scl <= n_scl; r_sda <= n_sda;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_scl_o      <= n_scl;
            r_sda_o      <= n_sda;
            r_busy       <= (n_phase != PH_IDLE);
            r_byte_valid <= n_byte_valid;
            r_read_data  <= n_read_data;
            r_last       <= n_last;
            r_done       <= n_done;
            r_nack       <= n_nack;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.scl_out    = r_scl_o;
    assign o_res.sda_out    = r_sda_o;
    assign o_res.busy_res   = r_busy;
    assign o_res.byte_valid = r_byte_valid;
    assign o_res.read_data  = r_read_data;
    assign o_res.last_byte  = r_last;
    assign o_res.done_res   = r_done;
    assign o_res.nack_error = r_nack;

endmodule

// ----- hdl/i2c_eeprom_master.sv -----
`timescale 1ns / 1ps
// I2C EEPROM master, top level: configuration registers, front end and engine.
// Depends on iem_pkg, iem_in_if, iem_out_if, iem_front and iem_engine.
//
// Each transaction on i_cmd (a one-microsecond tick carrying sampled SDA, or a
// byte-write / sequential-read command) yields exactly one result on o_res with
// the SCL/SDA drive after that step, busy, received byte and completion flags.
// The block takes one transaction per clock cycle: the front end queues up to
// QUEUE_DEPTH classified transactions, and the engine performs one sequencer
// step per cycle into a single result register, so results flow back to back
// while o_res.ready is high. An accepted transaction is held in the queue, then in the result register.
// Commands arriving while busy are answered but otherwise ignored.
module i2c_eeprom_master #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iem_in_if.sink      i_cmd,
    iem_out_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import iem_pkg::*;

    logic [6:0]  r_slave_addr;
    logic [15:0] r_write_wait;
    t_q_out      w_q;
    logic        w_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= SLAVE_ADDR_RST;
            r_write_wait <= WRITE_WAIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_data[6:0];
                CFG_WRITE_WAIT: r_write_wait <= i_cfg_data;
                default: ;
            endcase
        end
    end

    iem_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_q     (w_q),
        .i_pop   (w_pop)
    );

    iem_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q          (w_q),
        .o_pop        (w_pop),
        .i_slave_addr (r_slave_addr),
        .i_write_wait (r_write_wait),
        .o_res        (o_res)
    );

    // A received byte and the end of a transaction never share a result
    a_byte_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.byte_valid && o_res.done_res))
        else $error("byte and done in one result");

    // A missing acknowledge is only reported at completion
    a_nack_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.nack_error) |-> o_res.done_res)
        else $error("nack without done");

    // Completion leaves the master idle with both lines released
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.done_res) |->
            (!o_res.busy_res && o_res.scl_out && o_res.sda_out))
        else $error("done while still busy");

endmodule
